### src/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants, operation and status codes, and the memory request type
// for the positional list block.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int DEPTH    = 16;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 5;
	localparam int POS_W    = 5;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

### src/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram
// Entry store: one write port and one read port, read data registered.
// The read data holds while no read is enabled.
// ----------------------------------------------------------------------------
module pli_ram (
	input  logic                          clk,
	input  pli_pkg::mem_req_t             req,
	output logic [pli_pkg::WORD_W-1:0]    rdata
);
	import pli_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Operation sequencer: checks each item, moves entries through the store one
// read and one write per cycle, and holds the result register.
// ----------------------------------------------------------------------------
module pli_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [pli_pkg::FUNC_W-1:0]      func,
	input  logic [pli_pkg::POS_W-1:0]       position,
	input  logic signed [pli_pkg::WORD_W-1:0] item_value,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [pli_pkg::STATUS_W-1:0]    status,
	output logic                            has_value,
	output logic signed [pli_pkg::WORD_W-1:0] out_value,
	output logic [pli_pkg::COUNT_W-1:0]     new_count,
	output logic                            last,
	output pli_pkg::mem_req_t               mem_req,
	input  logic [pli_pkg::WORD_W-1:0]      mem_rdata
);
	import pli_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_FLUSH,
		S_PUT,
		S_DONE,
		S_READ
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]    rd_idx_q;
	logic [ADDR_W-1:0]    end_idx_q;
	logic [ADDR_W-1:0]    pos0_q;
	logic                 up_q;
	logic                 rd_all_q;
	logic [WORD_W-1:0]    val_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic                 wr_pend_s1;
	logic [ADDR_W-1:0]    wr_addr_s1;
	logic                 have_s1;
	logic [ADDR_W-1:0]    emit_idx_s1;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic                 out_hv_q;
	logic [WORD_W-1:0]    out_value_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic                 out_last_q;

	logic                 accept;
	logic                 out_free;
	logic                 out_load;
	logic                 can_issue;
	logic                 emit;
	logic [ADDR_W-1:0]    last_idx;
	logic [POS_W-1:0]     pos_m1;
	logic                 ins_range_bad;
	logic                 del_range_bad;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;
	assign last_idx   = ADDR_W'(count_q - 1'b1);
	assign pos_m1     = position - 1'b1;
	assign can_issue  = (state_q == S_READ) && !rd_all_q && (!have_s1 || out_free);
	assign emit       = (state_q == S_READ) && have_s1 && out_free;
	assign out_load   = ((state_q == S_DONE) && out_free) || emit;

	assign ins_range_bad = (position == '0) ||
		((COUNT_W+1)'(position) > ((COUNT_W+1)'(count_q) + 1'b1));
	assign del_range_bad = (position == '0) || (COUNT_W'(position) > count_q);

	always_comb begin
		mem_req.re    = 1'b0;
		mem_req.raddr = rd_idx_q;
		mem_req.we    = 1'b0;
		mem_req.waddr = wr_addr_s1;
		mem_req.wdata = mem_rdata;
		if (state_q == S_SHIFT) begin
			mem_req.re = 1'b1;
		end
		if (can_issue) begin
			mem_req.re = 1'b1;
		end
		if (wr_pend_s1) begin
			mem_req.we = 1'b1;
		end else if (state_q == S_PUT) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = pos0_q;
			mem_req.wdata = val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			end_idx_q    <= '0;
			pos0_q       <= '0;
			up_q         <= 1'b0;
			rd_all_q     <= 1'b0;
			val_q        <= '0;
			res_status_q <= ST_OK;
			wr_pend_s1   <= 1'b0;
			wr_addr_s1   <= '0;
			have_s1      <= 1'b0;
			emit_idx_s1  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_hv_q     <= 1'b0;
			out_value_q  <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			wr_pend_s1 <= (state_q == S_SHIFT);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q  <= item_value;
						pos0_q <= ADDR_W'(pos_m1);
						case (func)
							FN_INSERT: begin
								if (ins_range_bad) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else if (count_q == COUNT_W'(DEPTH)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= ST_OK;
									count_q      <= count_q + 1'b1;
									up_q         <= 1'b1;
									rd_idx_q     <= last_idx;
									end_idx_q    <= ADDR_W'(pos_m1);
									if (COUNT_W'(pos_m1) == count_q) begin
										state_q <= S_PUT;
									end else begin
										state_q <= S_SHIFT;
									end
								end
							end
							FN_DELETE: begin
								if (del_range_bad) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= ST_OK;
									count_q      <= count_q - 1'b1;
									up_q         <= 1'b0;
									rd_idx_q     <= ADDR_W'(position);
									end_idx_q    <= last_idx;
									if (COUNT_W'(position) == count_q) begin
										state_q <= S_DONE;
									end else begin
										state_q <= S_SHIFT;
									end
								end
							end
							FN_READ: begin
								res_status_q <= ST_OK;
								rd_idx_q     <= '0;
								rd_all_q     <= 1'b0;
								have_s1      <= 1'b0;
								if (count_q == '0) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								res_status_q <= ST_RANGE;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_SHIFT: begin
					wr_addr_s1 <= up_q ? rd_idx_q + 1'b1 : rd_idx_q - 1'b1;
					if (rd_idx_q == end_idx_q) begin
						state_q <= S_FLUSH;
					end else begin
						rd_idx_q <= up_q ? rd_idx_q - 1'b1 : rd_idx_q + 1'b1;
					end
				end
				S_FLUSH: begin
					state_q <= up_q ? S_PUT : S_DONE;
				end
				S_PUT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_hv_q     <= 1'b0;
						out_value_q  <= '0;
						out_count_q  <= count_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_READ: begin
					if (can_issue) begin
						emit_idx_s1 <= rd_idx_q;
						have_s1     <= 1'b1;
						if (rd_idx_q == last_idx) begin
							rd_all_q <= 1'b1;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end else if (emit) begin
						have_s1 <= 1'b0;
					end
					if (emit) begin
						out_status_q <= ST_OK;
						out_hv_q     <= 1'b1;
						out_value_q  <= mem_rdata;
						out_count_q  <= count_q;
						out_last_q   <= (emit_idx_s1 == last_idx);
						if (emit_idx_s1 == last_idx) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign status       = out_status_q;
	assign has_value    = out_hv_q;
	assign out_value    = out_value_q;
	assign new_count    = out_count_q;
	assign last         = out_last_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("entry count above capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_req.we)
		else $error("store written while idle");

	a_pending_read: assert property (@(posedge clk) disable iff (!arst_n)
		have_s1 |-> state_q == S_READ)
		else $error("read data pending outside a read");

	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FN_INSERT && count_q == COUNT_W'(DEPTH)
		|=> count_q == COUNT_W'(DEPTH))
		else $error("rejected insert changed the count");
`endif

endmodule

### src/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Insert at a position moves count - position + 1 entries, one per cycle,
// then writes the new entry; delete moves the entries after the position.
// A read streams one entry per cycle while the result side is not stalled.
// The single store port pair sets the pace.
// Reset clears the count and control state; the store is not cleared.
// ----------------------------------------------------------------------------
module positional_list_insert_delete (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [pli_pkg::FUNC_W-1:0]        func,
	input  logic [pli_pkg::POS_W-1:0]         position,
	input  logic signed [pli_pkg::WORD_W-1:0] item_value,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [pli_pkg::STATUS_W-1:0]      status,
	output logic                              has_value,
	output logic signed [pli_pkg::WORD_W-1:0] out_value,
	output logic [pli_pkg::COUNT_W-1:0]       new_count,
	output logic                              last
);
	import pli_pkg::*;

	mem_req_t          mem_req;
	logic [WORD_W-1:0] mem_rdata;

	pli_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	pli_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.position     (position),
		.item_value   (item_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.has_value    (has_value),
		.out_value    (out_value),
		.new_count    (new_count),
		.last         (last),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata)
	);

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list insert/delete testbench
// Drives insert, delete, read and unknown operations into the list block.
// Senders and receivers idle, mostly at random. A scoreboard keeps its own copy of
// the list and checks every result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

	import pli_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                has_value;
		logic [WORD_W-1:0]   value;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} list_result_t;

	class list_scoreboard;
		logic [WORD_W-1:0] cells[DEPTH];
		int len;
		list_result_t awaited_q[$];
		int errors, results_seen, items_seen, full_hits, range_hits, reads_seen, peak_len;

		function int pending();
			return awaited_q.size();
		endfunction

		function void note_item(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
			logic [WORD_W-1:0] v);
			list_result_t r;
			int i;
			int ip;
			ip = int'(p);
			r = '{status: ST_OK, has_value: 1'b0, value: '0, count: '0, last: 1'b1};
			items_seen++;
			case (f)
				FN_INSERT: begin
					if (ip < 1 || ip > len + 1) begin
						r.status = ST_RANGE;
					end else if (len >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						for (i = len; i >= ip; i--) cells[i] = cells[i - 1];
						cells[ip - 1] = v;
						len++;
					end
				end
				FN_DELETE: begin
					if (ip < 1 || ip > len) begin
						r.status = ST_RANGE;
					end else begin
						for (i = ip - 1; i + 1 < len; i++) cells[i] = cells[i + 1];
						len--;
					end
				end
				FN_READ: begin
					reads_seen++;
					for (i = 0; i < len; i++) begin
						r.has_value = 1'b1;
						r.value = cells[i];
						r.count = COUNT_W'(len);
						r.last = (i + 1 == len);
						awaited_q.push_back(r);
					end
					if (len != 0) return;
				end
				default: begin
					r.status = ST_RANGE;
				end
			endcase
			if (r.status == ST_FULL) full_hits++;
			if (r.status == ST_RANGE) range_hits++;
			if (len > peak_len) peak_len = len;
			r.count = COUNT_W'(len);
			awaited_q.push_back(r);
		endfunction

		function void check_result(list_result_t got);
			list_result_t exp;
			results_seen++;
			if (awaited_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with nothing outstanding: st=%0d hv=%0d v=%h n=%0d l=%0d",
						$realtime, got.status, got.has_value, got.value, got.count, got.last);
				return;
			end
			exp = awaited_q.pop_front();
			if (got.status !== exp.status || got.has_value !== exp.has_value ||
				got.value !== exp.value || got.count !== exp.count || got.last !== exp.last) begin
				errors++;
				if (errors <= 10)
					$display("%0t: expected st=%0d hv=%0d v=%h n=%0d l=%0d, got st=%0d hv=%0d v=%h n=%0d l=%0d",
						$realtime, exp.status, exp.has_value, exp.value, exp.count, exp.last,
						got.status, got.has_value, got.value, got.count, got.last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [FUNC_W-1:0] func = FN_READ;
	logic [POS_W-1:0] position = '0;
	logic signed [WORD_W-1:0] item_value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic has_value;
	logic signed [WORD_W-1:0] out_value;
	logic [COUNT_W-1:0] new_count;
	logic last;

	list_scoreboard sb = new;
	int cycles = 0;
	int burst_left = 0;

	positional_list_insert_delete i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.position(position),
		.item_value(item_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.has_value(has_value),
		.out_value(out_value),
		.new_count(new_count),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("positional_list_insert_delete: mismatch");
			$finish;
		end
		case ((cycles / 400) % 4)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 9) < 6);
			default: result_stall <= ((cycles % 9) < 4);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result('{status: status, has_value: has_value, value: out_value,
				count: new_count, last: last});
	end

	task automatic send_item(input int gap, input logic [FUNC_W-1:0] f,
		input logic [POS_W-1:0] p, input logic [WORD_W-1:0] v);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		func <= f;
		position <= p;
		item_value <= v;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_item(f, p, v);
	endtask

	task automatic wait_for_results();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
		return ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
	endfunction

	function automatic logic [WORD_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position(logic [FUNC_W-1:0] f);
		if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 31));
		if (f == FN_INSERT) return POS_W'($urandom_range(1, sb.len + 1));
		if (sb.len == 0) return POS_W'($urandom_range(0, 31));
		return POS_W'($urandom_range(1, sb.len));
	endfunction

	initial begin
		int n;
		int mode;
		int r;
		logic [FUNC_W-1:0] f;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(0, FN_READ, 5'd0, 32'h0);
		send_item(0, FN_DELETE, 5'd1, 32'h0);
		send_item(0, FN_INSERT, 5'd0, 32'h1234_5678);
		send_item(0, FN_INSERT, 5'd2, 32'h1234_5678);
		send_item(0, FN_INSERT, 5'd1, 32'h8000_0000);
		send_item(0, FN_INSERT, 5'd2, 32'h7fff_ffff);
		send_item(0, FN_INSERT, 5'd1, 32'hffff_ffff);
		send_item(0, FN_INSERT, 5'd2, 32'h0000_0000);
		send_item(0, FN_READ, 5'd0, 32'h0);
		send_item(0, FN_INSERT, 5'd31, 32'h5555_5555);
		send_item(0, FN_DELETE, 5'd0, 32'h0);
		send_item(0, FN_DELETE, 5'd31, 32'h0);
		send_item(0, FN_DELETE, 5'd5, 32'h0);
		send_item(0, FN_DELETE, 5'd4, 32'h0);
		send_item(0, FN_DELETE, 5'd1, 32'h0);
		send_item(0, FN_UNKNOWN, 5'd1, 32'haaaa_aaaa);
		send_item(0, FN_READ, 5'd0, 32'h0);
		send_item(0, FN_DELETE, 5'd1, 32'h0);
		send_item(0, FN_DELETE, 5'd1, 32'h0);
		send_item(0, FN_READ, 5'd0, 32'h0);
		wait_for_results();

		// Fill the store to capacity and one past it so the full status is seen.
		for (n = 0; n <= DEPTH; n++)
			send_item(next_gap(), FN_INSERT, POS_W'($urandom_range(1, sb.len + 1)), pick_value());
		send_item(next_gap(), FN_READ, 5'd0, 32'h0);

		for (n = 0; n < 250; n++) begin
			if (n % 60 == 59) wait_for_results();
			mode = (n / 30) % 3;
			r = $urandom_range(0, 99);
			case (mode)
				0: f = (r < 75) ? FN_INSERT : (r < 85) ? FN_DELETE : (r < 97) ? FN_READ : FN_UNKNOWN;
				1: f = (r < 15) ? FN_INSERT : (r < 85) ? FN_DELETE : (r < 97) ? FN_READ : FN_UNKNOWN;
				default: f = (r < 40) ? FN_INSERT : (r < 75) ? FN_DELETE : (r < 96) ? FN_READ
					: FN_UNKNOWN;
			endcase
			send_item(next_gap(), f, pick_position(f), pick_value());
		end

		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transfers (%0d reads) and checked %0d results.",
			sb.items_seen, sb.reads_seen, sb.results_seen);
		$display("Saw %0d full rejections, %0d range rejections, peak length %0d.",
			sb.full_hits, sb.range_hits, sb.peak_len);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("positional_list_insert_delete: match");
		end else begin
			$display("%0d errors, %0d results still outstanding.", sb.errors, sb.pending());
			$display("positional_list_insert_delete: mismatch");
		end
		$finish;
	end

endmodule
